FILE: hw/rtl/ufp_pkg.sv
// Package for the update frame parser: result record, codes and CRC step.
// Used by every module of the parser; no dependencies.
package ufp_pkg;

  localparam int unsigned HDR_BYTES = 12;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_WLEN_BAD  = 3'd1;
  localparam logic [2:0] ST_WRANGE    = 3'd2;
  localparam logic [2:0] ST_CRC_BAD   = 3'd3;
  localparam logic [2:0] ST_UNKNOWN   = 3'd4;
  localparam logic [2:0] ST_ELEN_BAD  = 3'd5;
  localparam logic [2:0] ST_SECTOR    = 3'd6;

  // Flash actions
  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_ERASE   = 2'd1;
  localparam logic [1:0] ACT_PROGRAM = 2'd2;
  localparam logic [1:0] ACT_RESTART = 2'd3;

  // Commands
  localparam logic [7:0] CMD_HELLO   = 8'd1;
  localparam logic [7:0] CMD_ERASE   = 8'd2;
  localparam logic [7:0] CMD_WRITE   = 8'd3;
  localparam logic [7:0] CMD_RESTART = 8'd4;

  // Register indexes
  localparam logic [1:0] REG_MAGIC  = 2'd0;
  localparam logic [1:0] REG_BASE   = 2'd1;
  localparam logic [1:0] REG_END    = 2'd2;
  localparam logic [1:0] REG_SECTOR = 2'd3;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // Frame summary handed from the front end to the back end
  typedef struct packed {
    logic [7:0]  command;
    logic [15:0] length;
    logic [31:0] sequence_no;
    logic        crc_ok;
    logic [31:0] first_word;   // payload bytes 0..3, little-endian
  } frame_t;

  typedef struct packed {
    logic [7:0]  reply_command;
    logic [2:0]  status;
    logic [31:0] sequence_res;
    logic [31:0] detail;
    logic [1:0]  action;
    logic [31:0] write_offset;
    logic [9:0]  write_bytes;
    logic        restart_pending;
  } reply_t;

  // One reflected CRC-32 byte step
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/update_frame_parser.sv
// Update frame parser top level: one received byte per item.
// A reply is built from the frame whose last byte is taken, passing through the
// front register as that byte is taken, a queue entry, then the reply register.
// Throughput one byte per cycle; input stall rises only when the reply side holds
// off and the two-entry queue has no room for one more frame.
// Synchronous reset restores register defaults, clears counters and valid flags.
module update_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = 516
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [7:0]  data_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  reply_command,
  output logic [2:0]  status,
  output logic [31:0] sequence_res,
  output logic [31:0] detail,
  output logic [1:0]  action,
  output logic [31:0] write_offset,
  output logic [9:0]  write_bytes,
  output logic        restart_pending,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] frame_magic, region_base, region_end;
  logic [7:0]  highest_sector;
  logic        in_acc;
  logic        fv, qv, qtake, qaf;
  ufp_pkg::frame_t ff, qd;
  ufp_pkg::reply_t rp;

  assign pready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic    <= 32'h55424153;
      region_base    <= 32'h08020000;
      region_end     <= 32'h080E0000;
      highest_sector <= 8'd7;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        ufp_pkg::REG_MAGIC:  frame_magic    <= pwdata;
        ufp_pkg::REG_BASE:   region_base    <= pwdata;
        ufp_pkg::REG_END:    region_end     <= pwdata;
        ufp_pkg::REG_SECTOR: highest_sector <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ufp_pkg::REG_MAGIC:  prdata = frame_magic;
      ufp_pkg::REG_BASE:   prdata = region_base;
      ufp_pkg::REG_END:    prdata = region_end;
      ufp_pkg::REG_SECTOR: prdata = {24'd0, highest_sector};
      default:             prdata = '0;
    endcase
  end

  // Hold bytes while the queue cannot take one more frame
  assign stall  = qaf;
  assign in_acc = valid && !stall;

  ufp_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_acc), .in_byte(data_byte),
    .frame_magic(frame_magic), .frm_valid(fv), .frm(ff)
  );

  ufp_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(fv), .wr_data(ff), .rd_valid(qv),
    .rd_take(qtake), .rd_data(qd), .almost_full(qaf)
  );

  ufp_back u_back (
    .clk(clk), .rst(rst), .frm_valid(qv), .frm(qd), .frm_take(qtake),
    .region_base(region_base), .region_end(region_end),
    .highest_sector(highest_sector), .out_valid(res_valid),
    .out_stall(res_stall), .reply(rp)
  );

  assign reply_command   = rp.reply_command;
  assign status          = rp.status;
  assign sequence_res    = rp.sequence_res;
  assign detail          = rp.detail;
  assign action          = rp.action;
  assign write_offset    = rp.write_offset;
  assign write_bytes     = rp.write_bytes;
  assign restart_pending = rp.restart_pending;
endmodule

FILE: hw/rtl/ufp_front.sv
// Front end: counts bytes, collects the header, runs the CRC, emits frames.
// Depends on ufp_pkg.
module ufp_front #(
  parameter int unsigned MAX_PAYLOAD = 516
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic [31:0]         frame_magic,
  output logic                frm_valid,
  output ufp_pkg::frame_t     frm
);
  localparam int unsigned FRAME_CAP = 12 + MAX_PAYLOAD + 4;
  localparam int unsigned CW = $clog2(FRAME_CAP + 1);

  logic [CW-1:0] bytes_seen;
  logic [CW-1:0] bytes_expected;
  logic [95:0]   header;
  logic [31:0]   running_crc;
  logic [31:0]   trailer_crc;
  logic [31:0]   first_word;

  logic [CW-1:0] seen_next;
  logic [15:0]   len_now;
  logic [95:0]   header_next;
  logic [31:0]   crc_next;
  logic [31:0]   trailer_next;
  logic [31:0]   first_next;
  logic          overrun;
  logic          hdr_drop;
  logic          frame_end;
  logic [CW-1:0] expected_next;
  logic [16:0]   pay_end;

  always_comb begin
    header_next   = header;
    crc_next      = running_crc;
    trailer_next  = trailer_crc;
    first_next    = first_word;
    seen_next     = bytes_seen + CW'(1);
    overrun       = bytes_seen >= CW'(FRAME_CAP);
    len_now       = header[63:48];
    pay_end       = 17'(len_now) + 17'(ufp_pkg::HDR_BYTES);
    if (bytes_seen < CW'(12)) begin
      header_next[bytes_seen[3:0]*8 +: 8] = in_byte;
      crc_next = ufp_pkg::crc_byte(running_crc, in_byte);
    end else if (17'(bytes_seen) < pay_end) begin
      if (bytes_seen < CW'(16))
        first_next[bytes_seen[1:0]*8 +: 8] = in_byte;
      crc_next = ufp_pkg::crc_byte(running_crc, in_byte);
    end else begin
      trailer_next = {in_byte, trailer_crc[31:8]};
    end
    hdr_drop = (seen_next == CW'(12)) &&
               ((header_next[31:0] != frame_magic) ||
                (header_next[63:48] > 16'(MAX_PAYLOAD)));
    expected_next = bytes_expected;
    if (seen_next == CW'(12))
      expected_next = CW'(header_next[63:48]) + CW'(16);
    frame_end = !overrun && !hdr_drop && (seen_next == expected_next) &&
                (bytes_seen >= CW'(12));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      bytes_expected <= '0;
      running_crc    <= '1;
      trailer_crc    <= '0;
      header         <= '0;
      frm_valid      <= 1'b0;
    end else begin
      frm_valid <= 1'b0;
      if (in_valid) begin
        if (overrun || hdr_drop || frame_end) begin
          bytes_seen     <= '0;
          bytes_expected <= '0;
          running_crc    <= '1;
          trailer_crc    <= '0;
        end else begin
          bytes_seen     <= seen_next;
          bytes_expected <= expected_next;
          running_crc    <= crc_next;
          trailer_crc    <= trailer_next;
        end
        if (!overrun) header <= header_next;
        first_word <= first_next;
        frm_valid  <= frame_end;
      end
    end
  end

  // Frame summary, registered with frm_valid
  always_ff @(posedge clk) begin
    if (in_valid && frame_end) begin
      frm.command     <= header_next[39:32];
      frm.length      <= header_next[63:48];
      frm.sequence_no <= header_next[95:64];
      frm.crc_ok      <= (~running_crc) == trailer_next;
      frm.first_word  <= first_next;
    end
  end
endmodule

FILE: hw/rtl/ufp_queue.sv
// Short queue between front and back end, two entries deep.
// Depends on ufp_pkg.
module ufp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  input  ufp_pkg::frame_t wr_data,
  output logic            rd_valid,
  input  logic            rd_take,
  output ufp_pkg::frame_t rd_data,
  output logic            almost_full
);
  ufp_pkg::frame_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign rd_valid    = count != 2'd0;
  assign rd_data     = slots[rd_ptr];
  // No room for one more frame: full, or the last slot is being written
  assign almost_full = count[1] || (count[0] && wr_valid);

  always_ff @(posedge clk) begin
    if (wr_valid) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_valid) wr_ptr <= ~wr_ptr;
      if (rd_take)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(wr_valid) - 2'(rd_take);
    end
  end
endmodule

FILE: hw/rtl/ufp_back.sv
// Back end: checks a finished frame and builds the registered reply.
// Depends on ufp_pkg.
module ufp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            frm_valid,
  input  ufp_pkg::frame_t frm,
  output logic            frm_take,
  input  logic [31:0]     region_base,
  input  logic [31:0]     region_end,
  input  logic [7:0]      highest_sector,
  output logic            out_valid,
  input  logic            out_stall,
  output ufp_pkg::reply_t reply
);
  logic            restart_flag;
  ufp_pkg::reply_t r;
  logic [31:0]     addr;
  logic [31:0]     nb;

  assign frm_take = frm_valid && (!out_valid || !out_stall);

  always_comb begin
    addr = region_base + frm.first_word;
    nb   = 32'(frm.length) - 32'd4;
    r = '0;
    r.reply_command   = frm.command | 8'h80;
    r.sequence_res    = frm.sequence_no;
    r.restart_pending = restart_flag;
    if (!frm.crc_ok) begin
      r.status = ufp_pkg::ST_CRC_BAD;
    end else begin
      case (frm.command)
        ufp_pkg::CMD_HELLO: r.detail = region_end - region_base;
        ufp_pkg::CMD_ERASE: begin
          if (frm.length != 16'd1) begin
            r.status = ufp_pkg::ST_ELEN_BAD;
          end else begin
            r.detail = {24'd0, frm.first_word[7:0]};
            if (frm.first_word[7:0] > highest_sector) r.status = ufp_pkg::ST_SECTOR;
            else r.action = ufp_pkg::ACT_ERASE;
          end
        end
        ufp_pkg::CMD_WRITE: begin
          if (frm.length < 16'd36 || nb[4:0] != 5'd0) begin
            r.status = ufp_pkg::ST_WLEN_BAD;
          end else if (addr < region_base || (addr + nb) > region_end ||
                       addr[4:0] != 5'd0) begin
            r.status = ufp_pkg::ST_WRANGE;
          end else begin
            r.action       = ufp_pkg::ACT_PROGRAM;
            r.write_offset = frm.first_word;
            r.write_bytes  = nb[9:0];
          end
        end
        ufp_pkg::CMD_RESTART: begin
          r.action          = ufp_pkg::ACT_RESTART;
          r.restart_pending = 1'b1;
        end
        default: r.status = ufp_pkg::ST_UNKNOWN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      restart_flag <= 1'b0;
    end else begin
      if (frm_take) begin
        out_valid    <= 1'b1;
        restart_flag <= r.restart_pending;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frm_take) reply <= r;
  end
endmodule

FILE: hw/rtl/ufp_checker.sv
// Port-level checker for the update frame parser, bound to the top level.
// Depends on ufp_pkg.
module ufp_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_stall,
  input logic [2:0]  status,
  input logic [1:0]  action,
  input logic [9:0]  write_bytes,
  input logic        restart_pending
);
  // A held reply keeps its status
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status))
    else $error("reply changed while stalled");

  // Actions only with status ok
  a_act: assert property (@(posedge clk) disable iff (rst)
    res_valid && action != ufp_pkg::ACT_NONE |-> status == ufp_pkg::ST_OK)
    else $error("action with error status");

  // Write sizes are whole 32-byte blocks
  a_wb: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> write_bytes[4:0] == 5'd0)
    else $error("write size misaligned");

  // Restart request reports the sticky flag
  a_rst: assert property (@(posedge clk) disable iff (rst)
    res_valid && action == ufp_pkg::ACT_RESTART |-> restart_pending)
    else $error("restart without flag");
endmodule

bind update_frame_parser ufp_checker u_checker (
  .clk(clk), .rst(rst), .res_valid(res_valid), .res_stall(res_stall),
  .status(status), .action(action), .write_bytes(write_bytes),
  .restart_pending(restart_pending)
);
